FILE: sv/qte_pkg.sv
// Shared types, constants and the CORDIC angle table for the quaternion to Euler block.
package qte_pkg;

  localparam int DW   = 36;   // Q.28 numerators and denominators
  localparam int XW   = 40;   // CORDIC x and y
  localparam int ZW   = 28;   // CORDIC angle, degrees * 65536
  localparam int RW   = 58;   // square root remainder and root
  localparam int SQN  = 29;   // root bits of a 57-bit radicand
  localparam int LANES = 3;

  localparam logic signed [DW-1:0] ONE_Q28  = 36'sd268435456;
  localparam logic signed [DW-1:0] NEG_ONE_Q28 = -36'sd268435456;
  localparam logic signed [ZW-1:0] DEG180   = 28'sd11796480;
  localparam logic signed [ZW-1:0] ROUND_ADD = 28'sd256;
  localparam logic signed [ZW-1:0] LIM_FULL = 28'sd23040;
  localparam logic signed [ZW-1:0] LIM_HALF = 28'sd11520;

  localparam int LANE_ROLL  = 0;
  localparam int LANE_PITCH = 1;
  localparam int LANE_YAW   = 2;

  typedef struct packed {
    logic signed [DW-1:0] nr;
    logic signed [DW-1:0] dr;
    logic signed [DW-1:0] ny;
    logic signed [DW-1:0] dy;
    logic signed [DW-1:0] s;
    logic                 sing;
  } num_t;

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0] ln;
    logic              sing;
  } cord_t;

  // atan(2^-i) in degrees * 65536
  function automatic logic signed [ZW-1:0] atan_deg16(input int i);
    logic signed [ZW-1:0] a;
    case (i)
      0:  a = 28'sd2949120;
      1:  a = 28'sd1740967;
      2:  a = 28'sd919879;
      3:  a = 28'sd466945;
      4:  a = 28'sd234379;
      5:  a = 28'sd117304;
      6:  a = 28'sd58666;
      7:  a = 28'sd29335;
      8:  a = 28'sd14668;
      9:  a = 28'sd7334;
      10: a = 28'sd3667;
      11: a = 28'sd1833;
      12: a = 28'sd917;
      13: a = 28'sd458;
      14: a = 28'sd229;
      15: a = 28'sd115;
      16: a = 28'sd57;
      17: a = 28'sd29;
      18: a = 28'sd14;
      19: a = 28'sd7;
      20: a = 28'sd4;
      21: a = 28'sd2;
      22: a = 28'sd1;
      default: a = 28'sd0;
    endcase
    return a;
  endfunction

  // fold the left half-plane onto the right one
  function automatic lane_t pre_rot(input logic signed [XW-1:0] y, input logic signed [XW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      l.z = (y >= 0) ? DEG180 : -DEG180;
      l.x = -x;
      l.y = -y;
    end else begin
      l.z = '0;
      l.x = x;
      l.y = y;
    end
    return l;
  endfunction

endpackage

FILE: sv/qte_in_if.sv
// Input channel: one quaternion word with valid/ready.
interface qte_in_if #(parameter int W = 16);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] comp0;
  logic signed [W-1:0] comp1;
  logic signed [W-1:0] comp2;
  logic signed [W-1:0] comp3;
  modport source (output valid, comp0, comp1, comp2, comp3, input ready);
  modport sink   (input valid, comp0, comp1, comp2, comp3, output ready);
endinterface

FILE: sv/qte_out_if.sv
// Output channel: roll, pitch, yaw and singular flag with valid/ready.
interface qte_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll;
  logic signed [14:0] pitch;
  logic signed [15:0] yaw;
  logic               singular;
  modport source (output valid, roll, pitch, yaw, singular, input ready);
  modport sink   (input valid, roll, pitch, yaw, singular, output ready);
endinterface

FILE: sv/quaternion_to_euler.sv
// Quaternion to roll/pitch/yaw: products, pipelined square root, three CORDIC lanes.
//
//  channel   dir  handshake            word
//  in_ch     in   valid/ready          comp0..comp3, Q2.(W-2)
//  out_ch    out  valid/ready          roll, pitch, yaw, singular
//  cfg       in   cfg_we               cfg_wdata = component_order
//
// One word per cycle while the output takes words; the path runs through the 29-stage
// root pipeline for the pitch cosine followed by the CORDIC stages.
// Reset clears valid bits, the order register and the output/skid stage.
// A stalled output parks one word in a skid register; ready is low while it is full.
module quaternion_to_euler #(
  parameter int COMPONENT_WIDTH = 16,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_wdata,
  qte_in_if.sink        in_ch,
  qte_out_if.source     out_ch
);
  import qte_pkg::*;

  localparam int CW  = COMPONENT_WIDTH;
  localparam int PW  = 2 * CW;
  localparam int FR2 = 2 * (CW - 2);
  localparam int SHR = (FR2 >= 28) ? FR2 - 28 : 0;
  localparam int SHL = (FR2 < 28) ? 28 - FR2 : 0;
  localparam int QW  = 32;
  localparam int NC  = CORDIC_STAGES;

  function automatic logic signed [QW-1:0] to_q28(input logic signed [PW-1:0] p);
    logic signed [63:0] e;
    e = 64'(p);
    if (FR2 >= 28) e = e >>> SHR;
    else           e = e <<< SHL;
    return e[QW-1:0];
  endfunction

  logic order;
  logic en;
  logic skid_v;
  assign en = !skid_v;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (rst) order <= 1'b0;
    else if (cfg_we) order <= cfg_wdata;
  end

  // stage A: reorder
  logic a_v;
  logic signed [CW-1:0] aw, ax, ay, az;
  always_ff @(posedge clk) begin
    if (rst) a_v <= 1'b0;
    else if (en) a_v <= in_ch.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (!order) begin
        aw <= CW'(in_ch.comp0); ax <= CW'(in_ch.comp1);
        ay <= CW'(in_ch.comp2); az <= CW'(in_ch.comp3);
      end else begin
        ax <= CW'(in_ch.comp0); ay <= CW'(in_ch.comp1);
        az <= CW'(in_ch.comp2); aw <= CW'(in_ch.comp3);
      end
    end
  end

  // stage B: exact products
  logic b_v;
  logic signed [PW-1:0] b_wx, b_yz, b_wy, b_zx, b_wz, b_xy, b_xx, b_yy, b_zz;
  always_ff @(posedge clk) begin
    if (rst) b_v <= 1'b0;
    else if (en) b_v <= a_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_wx <= aw * ax; b_yz <= ay * az; b_wy <= aw * ay;
      b_zx <= az * ax; b_wz <= aw * az; b_xy <= ax * ay;
      b_xx <= ax * ax; b_yy <= ay * ay; b_zz <= az * az;
    end
  end

  // stage C: Q.28 sums, saturated sine, singular test
  localparam logic [PW:0] HALF = (PW+1)'(1) << (FR2 - 1);
  logic c_v;
  num_t c_d, c_nx;
  always_comb begin
    logic signed [DW-1:0] t;
    logic [PW:0] s1, s2;
    t = DW'(to_q28(b_wx)) + DW'(to_q28(b_yz));
    c_nx.nr = t <<< 1;
    t = DW'(to_q28(b_xx)) + DW'(to_q28(b_yy));
    c_nx.dr = ONE_Q28 - (t <<< 1);
    t = DW'(to_q28(b_wz)) + DW'(to_q28(b_xy));
    c_nx.ny = t <<< 1;
    t = DW'(to_q28(b_yy)) + DW'(to_q28(b_zz));
    c_nx.dy = ONE_Q28 - (t <<< 1);
    t = (DW'(to_q28(b_wy)) - DW'(to_q28(b_zx))) <<< 1;
    if (t > ONE_Q28)          c_nx.s = ONE_Q28;
    else if (t < NEG_ONE_Q28) c_nx.s = NEG_ONE_Q28;
    else                      c_nx.s = t;
    s1 = {1'b0, b_xx} + {1'b0, b_yy};
    s2 = {1'b0, b_yy} + {1'b0, b_zz};
    c_nx.sing = (s1 == HALF) || (s2 == HALF);
  end
  always_ff @(posedge clk) begin
    if (rst) c_v <= 1'b0;
    else if (en) c_v <= b_v;
  end
  always_ff @(posedge clk) begin
    if (en) c_d <= c_nx;
  end

  // stage D: s^2
  logic d_v;
  num_t d_d;
  logic [59:0] d_sq;
  logic signed [29:0] sn;
  logic signed [59:0] sqp;
  assign sn  = c_d.s[29:0];
  assign sqp = sn * sn;
  always_ff @(posedge clk) begin
    if (rst) d_v <= 1'b0;
    else if (en) d_v <= c_v;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      d_d  <= c_d;
      d_sq <= sqp;
    end
  end

  // root pipeline: one root bit per stage
  logic          sq_val [SQN];
  logic [RW-1:0] sq_rem [SQN];
  logic [RW-1:0] sq_rt  [SQN];
  num_t          sq_d   [SQN];

  for (genvar k = 0; k < SQN; k++) begin : g_sqrt
    localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQN - 1 - k));
    logic          ival;
    logic [RW-1:0] irem, irt, trial;
    num_t          id;
    if (k == 0) begin : g_first
      assign ival = d_v;
      assign irem = (RW'(1) << 56) - RW'(d_sq);
      assign irt  = '0;
      assign id   = d_d;
    end else begin : g_rest
      assign ival = sq_val[k-1];
      assign irem = sq_rem[k-1];
      assign irt  = sq_rt[k-1];
      assign id   = sq_d[k-1];
    end
    assign trial = irt + BIT;
    always_ff @(posedge clk) begin
      if (rst) sq_val[k] <= 1'b0;
      else if (en) sq_val[k] <= ival;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sq_d[k] <= id;
        if (irem >= trial) begin
          sq_rem[k] <= irem - trial;
          sq_rt[k]  <= (irt >> 1) + BIT;
        end else begin
          sq_rem[k] <= irem;
          sq_rt[k]  <= irt >> 1;
        end
      end
    end
  end

  // pre-rotation
  logic  p_v;
  cord_t p_d;
  always_ff @(posedge clk) begin
    if (rst) p_v <= 1'b0;
    else if (en) p_v <= sq_val[SQN-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p_d.ln[LANE_ROLL]  <= pre_rot(XW'(sq_d[SQN-1].nr), XW'(sq_d[SQN-1].dr));
      p_d.ln[LANE_PITCH] <= pre_rot(XW'(sq_d[SQN-1].s), XW'(sq_rt[SQN-1]));
      p_d.ln[LANE_YAW]   <= pre_rot(XW'(sq_d[SQN-1].ny), XW'(sq_d[SQN-1].dy));
      p_d.sing           <= sq_d[SQN-1].sing;
    end
  end

  // CORDIC vectoring stages
  logic  cr_v [NC];
  cord_t cr_d [NC];
  for (genvar i = 0; i < NC; i++) begin : g_cordic
    localparam logic signed [ZW-1:0] ANG = atan_deg16(i);
    logic  ival;
    cord_t id, nx;
    if (i == 0) begin : g_first
      assign ival = p_v;
      assign id   = p_d;
    end else begin : g_rest
      assign ival = cr_v[i-1];
      assign id   = cr_d[i-1];
    end
    always_comb begin
      logic signed [XW-1:0] xs, ys;
      nx = id;
      for (int l = 0; l < LANES; l++) begin
        xs = id.ln[l].x >>> i;
        ys = id.ln[l].y >>> i;
        if (id.ln[l].y < 0) begin
          nx.ln[l].x = id.ln[l].x - ys;
          nx.ln[l].y = id.ln[l].y + xs;
          nx.ln[l].z = id.ln[l].z - ANG;
        end else begin
          nx.ln[l].x = id.ln[l].x + ys;
          nx.ln[l].y = id.ln[l].y - xs;
          nx.ln[l].z = id.ln[l].z + ANG;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (rst) cr_v[i] <= 1'b0;
      else if (en) cr_v[i] <= ival;
    end
    always_ff @(posedge clk) begin
      if (en) cr_d[i] <= nx;
    end
  end

  // round, clamp, zero-vector and singular override
  logic signed [ZW-1:0] ang [LANES];
  always_comb begin
    logic signed [ZW-1:0] t, lim;
    for (int l = 0; l < LANES; l++) begin
      lim = (l == LANE_PITCH) ? LIM_HALF : LIM_FULL;
      t = (cr_d[NC-1].ln[l].z + ROUND_ADD) >>> 9;
      if (t > lim)  t = lim;
      if (t < -lim) t = -lim;
      if (cr_d[NC-1].ln[l].zero || cr_d[NC-1].sing) t = '0;
      ang[l] = t;
    end
  end

  logic f_v;
  logic signed [15:0] f_roll, f_yaw;
  logic signed [14:0] f_pitch;
  logic f_sing;
  always_ff @(posedge clk) begin
    if (rst) f_v <= 1'b0;
    else if (en) f_v <= cr_v[NC-1];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      f_roll  <= ang[LANE_ROLL][15:0];
      f_pitch <= ang[LANE_PITCH][14:0];
      f_yaw   <= ang[LANE_YAW][15:0];
      f_sing  <= cr_d[NC-1].sing;
    end
  end

  // output register and skid
  logic out_v, push, pop;
  logic signed [15:0] o_roll, o_yaw, k_roll, k_yaw;
  logic signed [14:0] o_pitch, k_pitch;
  logic o_sing, k_sing;
  assign push = f_v && en;
  assign pop  = out_v && out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || pop) begin
      if (skid_v) begin
        out_v  <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end
  always_ff @(posedge clk) begin
    if (!out_v || pop) begin
      if (skid_v) begin
        o_roll <= k_roll; o_pitch <= k_pitch; o_yaw <= k_yaw; o_sing <= k_sing;
      end else begin
        o_roll <= f_roll; o_pitch <= f_pitch; o_yaw <= f_yaw; o_sing <= f_sing;
      end
    end else if (push) begin
      k_roll <= f_roll; k_pitch <= f_pitch; k_yaw <= f_yaw; k_sing <= f_sing;
    end
  end

  assign out_ch.valid    = out_v;
  assign out_ch.roll     = o_roll;
  assign out_ch.pitch    = o_pitch;
  assign out_ch.yaw      = o_yaw;
  assign out_ch.singular = o_sing;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst) skid_v |-> out_v)
    else $error("skid holds a word while output is empty");
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    (out_v && o_sing) |-> (o_roll == 0 && o_pitch == 0 && o_yaw == 0))
    else $error("singular word with nonzero angles");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (o_pitch <= 15'sd11520 && o_pitch >= -15'sd11520))
    else $error("pitch out of range");
  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_v && pop) |=> (out_v && !skid_v))
    else $error("skid word not moved to output");

endmodule

FILE: test/tb_quaternion_to_euler.sv
// Testbench for quaternion_to_euler: random and directed words checked against a built-in predictor.
`timescale 1ns / 100ps

module tb_quaternion_to_euler;
  import qte_pkg::*;

  localparam int CW = 16;
  localparam int STAGES = 16;
  localparam int LATENCY = STAGES + 40;
  localparam int WATCHDOG = 20000;
  localparam logic ORDER_WXYZ = 1'b0;
  localparam logic ORDER_XYZW = 1'b1;

  typedef struct {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               singular;
  } euler_t;

  class euler_scoreboard;
    logic   order;
    euler_t euler_q[$];
    int     errors;
    int     checked;
    int     singulars;

    function new();
      order = ORDER_WXYZ;
      errors = 0;
      checked = 0;
      singulars = 0;
    endfunction

    function longint atan2_deg(longint yv, longint xv, longint lim);
      longint z;
      longint xs;
      longint ys;
      longint r;
      longint tbl[16];
      tbl = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
              14668, 7334, 3667, 1833, 917, 458, 229, 115};
      z = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
        z = (yv >= 0) ? 64'sd11796480 : -64'sd11796480;
        xv = -xv;
        yv = -yv;
      end
      for (int i = 0; i < STAGES; i++) begin
        xs = xv >>> i;
        ys = yv >>> i;
        if (yv < 0) begin
          xv = xv - ys;
          yv = yv + xs;
          z -= tbl[i];
        end else begin
          xv = xv + ys;
          yv = yv - xs;
          z += tbl[i];
        end
      end
      r = (z + 256) >>> 9;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note(logic signed [CW-1:0] c0, logic signed [CW-1:0] c1,
                       logic signed [CW-1:0] c2, logic signed [CW-1:0] c3);
      longint w, x, y, z, dr, dy, s, c;
      euler_t e;
      if (order == ORDER_WXYZ) begin
        w = c0; x = c1; y = c2; z = c3;
      end else begin
        x = c0; y = c1; z = c2; w = c3;
      end
      e = '{0, 0, 0, 0};
      if (x * x + y * y == (64'sd1 << 27) || y * y + z * z == (64'sd1 << 27)) begin
        e.singular = 1'b1;
        singulars++;
      end else begin
        dr = (64'sd1 << 28) - 2 * (x * x + y * y);
        dy = (64'sd1 << 28) - 2 * (y * y + z * z);
        s = 2 * (w * y - z * x);
        if (s > (64'sd1 << 28)) s = 64'sd1 << 28;
        if (s < -(64'sd1 << 28)) s = -(64'sd1 << 28);
        c = longint'(root((64'd1 << 56) - longint'(s * s)));
        e.roll = 16'(atan2_deg(2 * (w * x + y * z), dr, 23040));
        e.pitch = 15'(atan2_deg(s, c, 11520));
        e.yaw = 16'(atan2_deg(2 * (w * z + x * y), dy, 23040));
      end
      euler_q.push_back(e);
    endfunction

    function void check(euler_t a);
      euler_t e;
      checked++;
      if (euler_q.size() == 0) begin
        $display("%0t: unexpected word roll=%0d pitch=%0d yaw=%0d sing=%0b",
                 $time, a.roll, a.pitch, a.yaw, a.singular);
        errors++;
        return;
      end
      e = euler_q.pop_front();
      if (a.roll !== e.roll || a.pitch !== e.pitch || a.yaw !== e.yaw ||
          a.singular !== e.singular) begin
        $display("%0t: mismatch expected roll=%0d pitch=%0d yaw=%0d sing=%0b",
                 $time, e.roll, e.pitch, e.yaw, e.singular);
        $display("%0t:          actual   roll=%0d pitch=%0d yaw=%0d sing=%0b",
                 $time, a.roll, a.pitch, a.yaw, a.singular);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_wdata;
  logic no_idle;
  int   stall_cnt;

  qte_in_if #(.W(CW)) in_ch ();
  qte_out_if out_ch ();

  euler_scoreboard sb;

  quaternion_to_euler #(
    .COMPONENT_WIDTH(CW),
    .CORDIC_STAGES  (STAGES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (no_idle) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= 30);
    end
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note(in_ch.comp0, in_ch.comp1, in_ch.comp2, in_ch.comp3);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check('{out_ch.roll, out_ch.pitch, out_ch.yaw, out_ch.singular});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt > WATCHDOG) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // w, x, y, z placed on the channel in the current component order
  task automatic send_quat(input logic [15:0] w, input logic [15:0] x,
                           input logic [15:0] y, input logic [15:0] z);
    while (!no_idle && $urandom_range(99) < 30) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    if (sb.order == ORDER_WXYZ) begin
      in_ch.comp0 <= w; in_ch.comp1 <= x; in_ch.comp2 <= y; in_ch.comp3 <= z;
    end else begin
      in_ch.comp0 <= x; in_ch.comp1 <= y; in_ch.comp2 <= z; in_ch.comp3 <= w;
    end
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_and_set(input logic order);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.euler_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= order;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.order = order;
  endtask

  function automatic logic [15:0] rand_comp(int kind);
    logic [15:0] v;
    case (kind)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(32768) - 16384);
      default: begin
        case ($urandom_range(5))
          0: v = 16'h8000;
          1: v = 16'h7fff;
          2: v = 16'h0000;
          3: v = 16'h4000;
          4: v = 16'hc000;
          default: v = 16'hffff;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic random_words(input int n);
    logic [15:0] q[4];
    int kind;
    for (int i = 0; i < n; i++) begin
      no_idle = (i >= n / 2 && i < n / 2 + 80);
      kind = $urandom_range(9);
      foreach (q[k]) q[k] = rand_comp(kind < 5 ? 0 : (kind < 8 ? 1 : 2));
      if (kind == 9) begin
        // x^2 + y^2 or y^2 + z^2 at one half: singular
        q[$urandom_range(1) * 2 + 1] = $urandom_range(1) ? 16'sd8192 : -16'sd8192;
        q[2] = $urandom_range(1) ? 16'sd8192 : -16'sd8192;
      end
      send_quat(q[0], q[1], q[2], q[3]);
    end
    no_idle = 1'b0;
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    no_idle = 1'b0;
    stall_cnt = 0;
    in_ch.valid = 1'b0;
    in_ch.comp0 = '0;
    in_ch.comp1 = '0;
    in_ch.comp2 = '0;
    in_ch.comp3 = '0;
    out_ch.ready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h0000, 16'h7fff, 16'h0000, 16'h0000);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7fff);
    send_quat(16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    send_quat(16'h7fff, 16'h0000, 16'h8000, 16'h0000);
    send_quat(16'h2d41, 16'h0000, 16'h2d41, 16'h0000);
    send_quat(16'h1234, 16'h2000, 16'h2000, 16'h0000);
    send_quat(16'h1234, 16'h0000, 16'h2000, 16'he000);
    send_quat(16'h2000, 16'h2000, 16'h2000, 16'h2000);
    send_quat(16'h8000, 16'h7fff, 16'h0000, 16'h8000);
    random_words(400);

    drain_and_set(ORDER_XYZW);
    send_quat(16'h4000, 16'h1000, 16'h2000, 16'h3000);
    send_quat(16'h0000, 16'h2000, 16'h2000, 16'h0000);
    send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    random_words(420);

    drain_and_set(ORDER_WXYZ);
    random_words(400);
    drain_and_set(ORDER_XYZW);
    random_words(400);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.euler_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);

    $display("Checked %0d quaternion words (%0d singular) across both component orders,",
             sb.checked, sb.singulars);
    $display("with directed extremes and random stalls on both sides.");
    if (sb.errors == 0 && sb.euler_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
